### sv/hsps_pkg.sv
// ----------------------------------------------------------------------------
// hsps_pkg
// Shared types and constants of the SPS size parser.
// ----------------------------------------------------------------------------
package hsps_pkg;

  localparam int HDR_BITS = 24;

  localparam logic [7:0] PROF_HIGH    = 8'd100;
  localparam logic [7:0] PROF_HIGH10  = 8'd110;
  localparam logic [7:0] PROF_HIGH422 = 8'd122;
  localparam logic [7:0] PROF_HIGH444 = 8'd144;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SHORT = 2'd1;
  localparam logic [1:0] STAT_LONG  = 2'd2;

  // one byte handed from the front to the back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } hsps_item_t;

endpackage

### sv/h264_sps_size_parser.sv
// ----------------------------------------------------------------------------
// h264_sps_size_parser
// Decodes the cropped frame size from the bytes of an H.264 SPS.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_* carries SPS bytes from the profile byte on, tlast on the final byte.
//   m_axis_* carries one request per parameter set: width, height, status.
//   A two-entry queue decouples the input from the bit-serial back end.
//   The back end loads each byte, then shifts its eight bits through the
//   Exp-Golomb decoder one bit per cycle; it takes no new byte until the
//   current one is through. After the last byte of a set the back end
//   presents the result, which holds until taken.
//   While the receiver stalls, the back end halts, the queue fills and then
//   s_axis_tready drops.
//   Reset (rst, synchronous) empties the queue and returns the parser to the
//   start of a parameter set; each taken result also restarts the parser.
// ----------------------------------------------------------------------------
module h264_sps_size_parser
  import hsps_pkg::*;
#(
  parameter int CODE_WIDTH = 32
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] sps_byte
  input  logic        s_axis_tlast,  // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [15:0] video_width, [31:16] video_height,
                                     // [33:32] parse_status, rest zero
);

  hsps_item_t  q_in, q_out;
  logic        q_valid, q_ready;
  logic [15:0] w, h;
  logic [1:0]  st;
  logic        busy;

  assign q_in.data = s_axis_tdata;
  assign q_in.last = s_axis_tlast;

  hsps_fifo u_fifo (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(q_in),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_out)
  );

  hsps_core #(.CODE_WIDTH(CODE_WIDTH)) u_core (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_out),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .res_width(w), .res_height(h), .res_status(st), .busy(busy)
  );

  assign m_axis_tdata = {6'd0, st, h, w};

`ifndef SYNTHESIS
  a_out_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[33:32] != 2'd3))
    else $error("bad status");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[33:32] != STAT_OK) |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("error result not zeroed");
  a_out_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> busy)
    else $error("result without busy core");
`endif

endmodule

### sv/hsps_fifo.sv
// ----------------------------------------------------------------------------
// hsps_fifo
// Front part: accepts input bytes into a two-entry queue.
// ----------------------------------------------------------------------------
module hsps_fifo
  import hsps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  hsps_item_t in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output hsps_item_t out_item
);

  hsps_item_t  mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (out_valid && out_ready) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
    end
  end

endmodule

### sv/hsps_core.sv
// ----------------------------------------------------------------------------
// hsps_core
// Back part: walks each loaded byte one bit per cycle through the SPS syntax; it takes the next byte only when idle.
// ----------------------------------------------------------------------------
module hsps_core
  import hsps_pkg::*;
#(
  parameter int CODE_WIDTH = 32
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  hsps_item_t  in_item,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [15:0] res_width,
  output logic [15:0] res_height,
  output logic [1:0]  res_status,
  output logic        busy
);

  typedef enum logic [31:0] {
    S_HDR = 32'd1 << 0, S_SPS_ID = 32'd1 << 1, S_CHROMA = 32'd1 << 2,
    S_SEP = 32'd1 << 3, S_LUMA = 32'd1 << 4, S_CDEPTH = 32'd1 << 5,
    S_BYPASS = 32'd1 << 6, S_MFLAG = 32'd1 << 7, S_LFLAG = 32'd1 << 8,
    S_DELTA = 32'd1 << 9, S_LOG2FN = 32'd1 << 10, S_POCT = 32'd1 << 11,
    S_POCLSB = 32'd1 << 12, S_POCZ = 32'd1 << 13, S_NONREF = 32'd1 << 14,
    S_TOPBOT = 32'd1 << 15, S_CYCLE = 32'd1 << 16, S_REFOFF = 32'd1 << 17,
    S_NUMREF = 32'd1 << 18, S_GAPS = 32'd1 << 19, S_WIDTH = 32'd1 << 20,
    S_HEIGHT = 32'd1 << 21, S_FONLY = 32'd1 << 22, S_MBAFF = 32'd1 << 23,
    S_DIR8 = 32'd1 << 24, S_CFLAG = 32'd1 << 25, S_CROP0 = 32'd1 << 26,
    S_CROP1 = 32'd1 << 27, S_CROP2 = 32'd1 << 28, S_CROP3 = 32'd1 << 29,
    S_DONE = 32'd1 << 30, S_ERR = 32'd1 << 31
  } step_t;

  typedef enum logic [2:0] {
    P_IDLE = 3'b001, P_BITS = 3'b010, P_OUT = 3'b100
  } phase_t;

  localparam int LZW = $clog2(CODE_WIDTH);

  phase_t                phase;
  step_t                 step;
  logic [7:0]            sh;
  logic                  last;
  logic [2:0]            bit_cnt;
  logic [4:0]            hdr_cnt;
  logic [LZW-1:0]        lz;
  logic [LZW-1:0]        sfx;
  logic [CODE_WIDTH-1:0] code;
  logic [7:0]            profile;
  logic [3:0]            list_idx;
  logic [6:0]            entry_cnt;
  logic [7:0]            last_scale;
  logic [31:0]           ref_left;
  logic [31:0]           width_mbs;
  logic [31:0]           height_units;
  logic                  frame_only;
  logic [31:0]           crop0, crop1, crop2, crop3;
  logic                  err_long;

  // Exp-Golomb bit decoder
  logic                  bitv;
  logic                  g_done;
  logic                  g_err;
  logic [31:0]           g_val;
  logic [CODE_WIDTH-1:0] code_sh;
  logic                  is_golomb;
  logic [31:0]           sval;
  logic [7:0]            nscale;
  logic [6:0]            list_size;

  assign bitv    = sh[7];
  assign code_sh = {code[CODE_WIDTH-2:0], bitv};
  assign is_golomb = (step == S_SPS_ID) || (step == S_CHROMA) || (step == S_LUMA) ||
                     (step == S_CDEPTH) || (step == S_DELTA) || (step == S_LOG2FN) ||
                     (step == S_POCT) || (step == S_POCLSB) || (step == S_NONREF) ||
                     (step == S_TOPBOT) || (step == S_CYCLE) || (step == S_REFOFF) ||
                     (step == S_NUMREF) || (step == S_WIDTH) || (step == S_HEIGHT) ||
                     (step == S_CROP0) || (step == S_CROP1) || (step == S_CROP2) ||
                     (step == S_CROP3);

  always_comb begin
    g_done = 1'b0;
    g_err  = 1'b0;
    g_val  = 32'd0;
    if (code == '0) begin
      if (!bitv) begin
        g_err = (lz == LZW'(CODE_WIDTH - 1));
      end else if (lz == '0) begin
        g_done = 1'b1;
      end
    end else if (sfx == LZW'(1)) begin
      g_done = 1'b1;
      g_val  = 32'(code_sh) - 32'd1;
    end
  end

  always_comb begin
    if (g_val[0]) sval = {1'b0, g_val[31:1]} + 32'd1;
    else          sval = 32'd0 - {1'b0, g_val[31:1]};
  end
  assign nscale    = last_scale + sval[7:0];
  assign list_size = (list_idx < 4'd6) ? 7'd16 : 7'd64;

  assign in_ready  = (phase == P_IDLE);
  assign res_valid = (phase == P_OUT);
  assign busy      = (phase != P_IDLE);

  logic [31:0] w_full, h_full;
  assign w_full = (width_mbs << 4) - (crop0 << 1) - (crop1 << 1);
  assign h_full = ((frame_only ? height_units : (height_units << 1)) << 4)
                  - (crop2 << 1) - (crop3 << 1);

  // parse state holds while the request waits, so derive it straight from there
  always_comb begin
    if (err_long || (step == S_ERR)) begin
      res_status = STAT_LONG;
      res_width  = 16'd0;
      res_height = 16'd0;
    end else if (step != S_DONE) begin
      res_status = STAT_SHORT;
      res_width  = 16'd0;
      res_height = 16'd0;
    end else begin
      res_status = STAT_OK;
      res_width  = w_full[15:0];
      res_height = h_full[15:0];
    end
  end

  // wipe the per-set state after the result
  logic clr;
  assign clr = rst || (phase == P_OUT && res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= P_IDLE;
      bit_cnt <= 3'd0;
    end else begin
      unique case (phase)
        P_IDLE: if (in_valid) begin
          sh      <= in_item.data;
          last    <= in_item.last;
          bit_cnt <= 3'd0;
          phase   <= P_BITS;
        end
        P_BITS: begin
          sh      <= {sh[6:0], 1'b0};
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) phase <= last ? P_OUT : P_IDLE;
        end
        P_OUT: if (res_ready) phase <= P_IDLE;
        default: phase <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      step       <= S_HDR;
      hdr_cnt    <= 5'd0;
      lz         <= '0;
      sfx        <= '0;
      code       <= '0;
      profile    <= 8'd0;
      list_idx   <= 4'd0;
      entry_cnt  <= 7'd0;
      last_scale <= 8'd8;
      ref_left   <= 32'd0;
      width_mbs  <= 32'd0;
      height_units <= 32'd0;
      frame_only <= 1'b0;
      crop0 <= 32'd0; crop1 <= 32'd0; crop2 <= 32'd0; crop3 <= 32'd0;
      err_long   <= 1'b0;
    end else if (phase == P_BITS && step != S_DONE && step != S_ERR) begin
      if (step == S_HDR) begin
        if (hdr_cnt < 5'd8) profile <= {profile[6:0], bitv};
        if (hdr_cnt == 5'(HDR_BITS - 1)) begin
          hdr_cnt <= 5'd0;
          step    <= S_SPS_ID;
        end else begin
          hdr_cnt <= hdr_cnt + 5'd1;
        end
      end else if (!is_golomb) begin
        priority case (step)
          S_SEP:    step <= S_LUMA;
          S_BYPASS: step <= S_MFLAG;
          S_MFLAG:  begin
            list_idx <= 4'd0;
            step     <= bitv ? S_LFLAG : S_LOG2FN;
          end
          S_LFLAG: begin
            if (bitv) begin
              entry_cnt  <= 7'd0;
              last_scale <= 8'd8;
              step       <= S_DELTA;
            end else begin
              list_idx <= list_idx + 4'd1;
              step     <= (list_idx >= 4'd7) ? S_LOG2FN : S_LFLAG;
            end
          end
          S_POCZ:  step <= S_NONREF;
          S_GAPS:  step <= S_WIDTH;
          S_FONLY: begin
            frame_only <= bitv;
            step       <= bitv ? S_DIR8 : S_MBAFF;
          end
          S_MBAFF: step <= S_DIR8;
          S_DIR8:  step <= S_CFLAG;
          S_CFLAG: step <= bitv ? S_CROP0 : S_DONE;
          default: step <= step;
        endcase
      end else if (g_err) begin
        err_long <= 1'b1;
        step     <= S_ERR;
      end else if (!g_done) begin
        if (code == '0) begin
          if (!bitv) lz <= lz + LZW'(1);
          else begin
            code <= CODE_WIDTH'(1);
            sfx  <= lz;
          end
        end else begin
          code <= code_sh;
          sfx  <= sfx - LZW'(1);
        end
      end else begin
        code <= '0;
        lz   <= '0;
        sfx  <= '0;
        priority case (step)
          S_SPS_ID: step <= (profile == PROF_HIGH || profile == PROF_HIGH10 ||
                             profile == PROF_HIGH422 || profile == PROF_HIGH444) ?
                            S_CHROMA : S_LOG2FN;
          S_CHROMA: step <= (g_val == 32'd3) ? S_SEP : S_LUMA;
          S_LUMA:   step <= S_CDEPTH;
          S_CDEPTH: step <= S_BYPASS;
          S_DELTA: begin
            if (nscale != 8'd0) last_scale <= nscale;
            entry_cnt <= entry_cnt + 7'd1;
            if (nscale == 8'd0 || (entry_cnt + 7'd1) >= list_size) begin
              list_idx <= list_idx + 4'd1;
              step     <= (list_idx >= 4'd7) ? S_LOG2FN : S_LFLAG;
            end
          end
          S_LOG2FN: step <= S_POCT;
          S_POCT:   step <= (g_val == 32'd0) ? S_POCLSB :
                            (g_val == 32'd1) ? S_POCZ : S_NUMREF;
          S_POCLSB: step <= S_NUMREF;
          S_NONREF: step <= S_TOPBOT;
          S_TOPBOT: step <= S_CYCLE;
          S_CYCLE: begin
            ref_left <= g_val;
            step     <= (g_val == 32'd0) ? S_NUMREF : S_REFOFF;
          end
          S_REFOFF: begin
            ref_left <= ref_left - 32'd1;
            if (ref_left == 32'd1) step <= S_NUMREF;
          end
          S_NUMREF: step <= S_GAPS;
          S_WIDTH:  begin width_mbs <= g_val + 32'd1; step <= S_HEIGHT; end
          S_HEIGHT: begin height_units <= g_val + 32'd1; step <= S_FONLY; end
          S_CROP0:  begin crop0 <= g_val; step <= S_CROP1; end
          S_CROP1:  begin crop1 <= g_val; step <= S_CROP2; end
          S_CROP2:  begin crop2 <= g_val; step <= S_CROP3; end
          S_CROP3:  begin crop3 <= g_val; step <= S_DONE; end
          default:  step <= step;
        endcase
      end
    end
  end

endmodule

### verif/tb_h264_sps_size_parser.sv
// ----------------------------------------------------------------------------
// tb_h264_sps_size_parser
// Streams SPS byte sets into the size parser and checks every size/status
// request against a bit-serial predictor or directed rows, under varying back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_h264_sps_size_parser;
  import hsps_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int WDOG_LIMIT  = 5000;

  typedef enum logic [5:0] {
    S_HDR, S_SPS_ID, S_CHROMA, S_SEP_PLANE, S_LUMA, S_CDEPTH, S_BYPASS, S_MATRIX,
    S_LIST_FLAG, S_DELTA, S_LOG2_FN, S_POC_TYPE, S_POC_LSB, S_POC_ZERO, S_NONREF,
    S_TOPBOT, S_CYCLE, S_REF_OFF, S_NUM_REF, S_GAPS, S_WIDTH, S_HEIGHT, S_FRAME,
    S_MBAFF, S_DIRECT8, S_CROP_FLAG, S_CROP0, S_CROP1, S_CROP2, S_CROP3, S_DONE,
    S_ERR
  } sps_step_t;

  typedef struct {
    logic [15:0] width;
    logic [15:0] height;
    logic [1:0]  status;
  } size_res_t;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    bit          typed;
    logic [15:0] width;
    logic [15:0] height;
    logic [1:0]  status;
  } sps_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;

  h264_sps_size_parser DUT (.*);

  initial begin
    clk = 1'b0;
  end
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sps_row_t  byte_q[$];
  size_res_t size_q[$];
  int        snd_idle = 0;
  int        rcv_idle = 0;
  int        err_count = 0;
  int        hold_kick = 0;
  int        hold_seen = 0;
  int        hold_left = 0;
  int        quiet_cycles = 0;

  // predictor state
  sps_step_t   p_step;
  int          p_hdr_cnt;
  int          p_lead;
  int          p_suffix;
  logic [31:0] p_code;
  logic [7:0]  p_prof;
  int          p_list;
  int          p_entry;
  logic [7:0]  p_last_sc;
  logic [7:0]  p_next_sc;
  logic [31:0] p_cycle;
  logic [31:0] p_wmbs;
  logic [31:0] p_hunits;
  logic        p_frame;
  logic [31:0] p_crop[4];
  logic [1:0]  p_err;

  function automatic void pred_reset();
    p_step = S_HDR;
    p_hdr_cnt = 0;
    p_lead = 0;
    p_suffix = 0;
    p_code = '0;
    p_prof = '0;
    p_list = 0;
    p_entry = 0;
    p_last_sc = 8'd8;
    p_next_sc = 8'd8;
    p_cycle = '0;
    p_wmbs = '0;
    p_hunits = '0;
    p_frame = 1'b0;
    foreach (p_crop[i]) p_crop[i] = '0;
    p_err = '0;
  endfunction

  // 1 code done, 0 more bits, -1 code too long
  function automatic int golomb_bit(input bit b, output logic [31:0] val);
    val = '0;
    if (p_code == 0) begin
      if (!b) begin
        if (p_lead >= 31) return -1;
        p_lead++;
        return 0;
      end
      if (p_lead == 0) return 1;
      p_code = 32'd1;
      p_suffix = p_lead;
      return 0;
    end
    p_code = {p_code[30:0], b};
    p_suffix--;
    if (p_suffix == 0) begin
      val = p_code - 32'd1;
      p_code = '0;
      p_lead = 0;
      return 1;
    end
    return 0;
  endfunction

  function automatic void next_list();
    p_list++;
    p_step = (p_list >= 8) ? S_LOG2_FN : S_LIST_FLAG;
  endfunction

  function automatic void parse_bit(input bit b);
    logic [31:0] v;
    logic [31:0] sv;
    int r;
    int size;
    if (p_step == S_DONE || p_step == S_ERR) return;
    if (p_step == S_HDR) begin
      if (p_hdr_cnt < 8) p_prof = {p_prof[6:0], b};
      p_hdr_cnt++;
      if (p_hdr_cnt >= HDR_BITS) begin
        p_hdr_cnt = 0;
        p_step = S_SPS_ID;
      end
      return;
    end
    case (p_step)
      S_SEP_PLANE: begin p_step = S_LUMA; return; end
      S_BYPASS:    begin p_step = S_MATRIX; return; end
      S_MATRIX: begin
        if (b) begin p_list = 0; p_step = S_LIST_FLAG; end
        else p_step = S_LOG2_FN;
        return;
      end
      S_LIST_FLAG: begin
        if (b) begin
          p_entry = 0;
          p_last_sc = 8'd8;
          p_next_sc = 8'd8;
          p_step = S_DELTA;
        end else next_list();
        return;
      end
      S_POC_ZERO:  begin p_step = S_NONREF; return; end
      S_GAPS:      begin p_step = S_WIDTH; return; end
      S_FRAME: begin
        p_frame = b;
        p_step = b ? S_DIRECT8 : S_MBAFF;
        return;
      end
      S_MBAFF:     begin p_step = S_DIRECT8; return; end
      S_DIRECT8:   begin p_step = S_CROP_FLAG; return; end
      S_CROP_FLAG: begin p_step = b ? S_CROP0 : S_DONE; return; end
      default: ;
    endcase
    r = golomb_bit(b, v);
    if (r < 0) begin
      p_err = STAT_LONG;
      p_step = S_ERR;
      return;
    end
    if (r == 0) return;
    case (p_step)
      S_SPS_ID: p_step = (p_prof == PROF_HIGH || p_prof == PROF_HIGH10 ||
                          p_prof == PROF_HIGH422 || p_prof == PROF_HIGH444) ?
                         S_CHROMA : S_LOG2_FN;
      S_CHROMA: p_step = (v == 32'd3) ? S_SEP_PLANE : S_LUMA;
      S_LUMA:   p_step = S_CDEPTH;
      S_CDEPTH: p_step = S_BYPASS;
      S_DELTA: begin
        size = (p_list < 6) ? 16 : 64;
        sv = v[0] ? (v >> 1) + 32'd1 : 32'd0 - (v >> 1);
        p_next_sc = p_last_sc + sv[7:0];
        if (p_next_sc != 0) p_last_sc = p_next_sc;
        p_entry++;
        if (p_next_sc == 0 || p_entry >= size) next_list();
      end
      S_LOG2_FN:  p_step = S_POC_TYPE;
      S_POC_TYPE: p_step = (v == 0) ? S_POC_LSB : (v == 1) ? S_POC_ZERO : S_NUM_REF;
      S_POC_LSB:  p_step = S_NUM_REF;
      S_NONREF:   p_step = S_TOPBOT;
      S_TOPBOT:   p_step = S_CYCLE;
      S_CYCLE: begin
        p_cycle = v;
        p_step = (v == 0) ? S_NUM_REF : S_REF_OFF;
      end
      S_REF_OFF: begin
        p_cycle = p_cycle - 32'd1;
        if (p_cycle == 0) p_step = S_NUM_REF;
      end
      S_NUM_REF: p_step = S_GAPS;
      S_WIDTH:   begin p_wmbs = v + 32'd1; p_step = S_HEIGHT; end
      S_HEIGHT:  begin p_hunits = v + 32'd1; p_step = S_FRAME; end
      S_CROP0:   begin p_crop[0] = v; p_step = S_CROP1; end
      S_CROP1:   begin p_crop[1] = v; p_step = S_CROP2; end
      S_CROP2:   begin p_crop[2] = v; p_step = S_CROP3; end
      S_CROP3:   begin p_crop[3] = v; p_step = S_DONE; end
      default: ;
    endcase
  endfunction

  function automatic bit size_of_byte(input logic [7:0] by, input logic lst,
                                      output size_res_t res);
    logic [31:0] w;
    logic [31:0] h;
    for (int j = 7; j >= 0; j--) parse_bit(by[j]);
    res = '{default: '0};
    if (!lst) return 0;
    if (p_err == STAT_LONG) res.status = STAT_LONG;
    else if (p_step != S_DONE) res.status = STAT_SHORT;
    else res.status = STAT_OK;
    if (res.status == STAT_OK) begin
      w = p_wmbs * 32'd16 - 32'd2 * p_crop[0] - 32'd2 * p_crop[1];
      h = (32'd2 - 32'(p_frame)) * p_hunits * 32'd16 - 32'd2 * p_crop[2]
          - 32'd2 * p_crop[3];
      res.width = w[15:0];
      res.height = h[15:0];
    end
    pred_reset();
    return 1;
  endfunction

  // ---------------- stimulus generation ----------------
  bit gen_bits[$];

  function automatic void put_ue(input logic [31:0] v);
    logic [32:0] x;
    int n;
    x = {1'b0, v} + 33'd1;
    n = 32;
    while (!x[n]) n--;
    repeat (n) gen_bits.push_back(1'b0);
    for (int i = n; i >= 0; i--) gen_bits.push_back(x[i]);
  endfunction

  function automatic void put_se(input int d);
    if (d > 0) put_ue(32'(2 * d - 1));
    else put_ue(32'(-2 * d));
  endfunction

  function automatic logic [31:0] pick_size();
    if ($urandom_range(15) == 0) return $urandom;
    return $urandom_range(0, 120);
  endfunction

  // mode 0 well-formed, 1 cut short, 2 over-long code
  function automatic void add_sps(input int mode);
    logic [7:0] prof;
    int ls, ns, d, size, ptype, cyc, cut;
    bit fo;
    gen_bits.delete();
    case ($urandom_range(7))
      0: prof = PROF_HIGH;
      1: prof = PROF_HIGH10;
      2: prof = PROF_HIGH422;
      3: prof = PROF_HIGH444;
      4: prof = 8'd66;
      5: prof = 8'd77;
      default: prof = 8'($urandom);
    endcase
    for (int i = 7; i >= 0; i--) gen_bits.push_back(prof[i]);
    repeat (16) gen_bits.push_back(1'($urandom_range(1)));
    put_ue($urandom_range(0, 31));
    if (prof == PROF_HIGH || prof == PROF_HIGH10 || prof == PROF_HIGH422 ||
        prof == PROF_HIGH444) begin
      d = $urandom_range(0, 3);
      put_ue(32'(d));
      if (d == 3) gen_bits.push_back(1'($urandom_range(1)));
      put_ue($urandom_range(0, 6));
      put_ue($urandom_range(0, 6));
      gen_bits.push_back(1'($urandom_range(1)));
      if ($urandom_range(1)) begin
        gen_bits.push_back(1'b1);
        for (int l = 0; l < 8; l++) begin
          if ($urandom_range(1)) begin
            gen_bits.push_back(1'b1);
            size = (l < 6) ? 16 : 64;
            ls = 8;
            for (int e = 0; e < size; e++) begin
              if ($urandom_range(15) == 0) d = -ls;
              else d = $urandom_range(0, 255) - 128;
              put_se(d);
              ns = (ls + d) & 255;
              if (ns == 0) break;
              ls = ns;
            end
          end else gen_bits.push_back(1'b0);
        end
      end else gen_bits.push_back(1'b0);
    end
    put_ue($urandom_range(0, 12));
    ptype = $urandom_range(0, 3);
    if (ptype == 3) put_ue($urandom_range(2, 1000));
    else put_ue(32'(ptype));
    if (ptype == 0) put_ue($urandom_range(0, 12));
    if (ptype == 1) begin
      gen_bits.push_back(1'($urandom_range(1)));
      put_se($urandom_range(0, 2000) - 1000);
      put_se($urandom_range(0, 2000) - 1000);
      cyc = $urandom_range(0, 4);
      put_ue(32'(cyc));
      repeat (cyc) put_se($urandom_range(0, 200) - 100);
    end
    put_ue($urandom_range(0, 16));
    gen_bits.push_back(1'($urandom_range(1)));
    put_ue(pick_size());
    put_ue(pick_size());
    fo = 1'($urandom_range(1));
    gen_bits.push_back(fo);
    if (!fo) gen_bits.push_back(1'($urandom_range(1)));
    gen_bits.push_back(1'($urandom_range(1)));
    if ($urandom_range(1)) begin
      gen_bits.push_back(1'b1);
      repeat (4) put_ue(($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 20));
    end else gen_bits.push_back(1'b0);
    repeat ($urandom_range(0, 16)) gen_bits.push_back(1'($urandom_range(1)));
    if (mode == 1) begin
      cut = $urandom_range(1, gen_bits.size() - 1);
      while (gen_bits.size() > cut) void'(gen_bits.pop_back());
    end else if (mode == 2) begin
      cut = $urandom_range(24, gen_bits.size());
      while (gen_bits.size() > cut) void'(gen_bits.pop_back());
      repeat (40) gen_bits.push_back(1'b0);
      repeat ($urandom_range(0, 10)) gen_bits.push_back(1'($urandom_range(1)));
    end
    while (gen_bits.size() % 8 != 0) gen_bits.push_back(1'($urandom_range(1)));
    for (int b = 0; b < gen_bits.size(); b += 8) begin
      sps_row_t row;
      row = '{default: '0};
      for (int i = 0; i < 8; i++) row.data[7 - i] = gen_bits[b + i];
      row.last = (b + 8 == gen_bits.size());
      byte_q.push_back(row);
    end
  endfunction

  function automatic void add_random(input int n_bytes);
    int target;
    int pick;
    sps_row_t row;
    target = byte_q.size() + n_bytes;
    while (byte_q.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 75) add_sps(0);
      else if (pick < 85) add_sps(1);
      else if (pick < 95) add_sps(2);
      else begin
        // noise: raw bytes with a random end marker
        repeat ($urandom_range(1, 6)) begin
          row = '{default: '0};
          row.data = 8'($urandom);
          row.last = ($urandom_range(3) == 0);
          byte_q.push_back(row);
        end
        byte_q[$].last = 1'b1;
      end
    end
  endfunction

  sps_row_t dir_rows[18] = '{
    // lone byte marked last: set ends inside the header
    '{8'h00, 1'b1, 1'b1, 16'd0, 16'd0, STAT_SHORT},
    // zeros after the header: code too long
    '{8'h42, 1'b0, 1'b0, 16'd0, 16'd0, STAT_OK},
    '{8'h00, 1'b0, 1'b0, 16'd0, 16'd0, STAT_OK},
    '{8'h1E, 1'b0, 1'b0, 16'd0, 16'd0, STAT_OK},
    '{8'h00, 1'b0, 1'b0, 16'd0, 16'd0, STAT_OK},
    '{8'h00, 1'b0, 1'b0, 16'd0, 16'd0, STAT_OK},
    '{8'h00, 1'b0, 1'b0, 16'd0, 16'd0, STAT_OK},
    '{8'h00, 1'b0, 1'b0, 16'd0, 16'd0, STAT_OK},
    '{8'h00, 1'b1, 1'b1, 16'd0, 16'd0, STAT_LONG},
    // all ones: smallest frame, cropping present but zero
    '{8'hFF, 1'b0, 1'b0, 16'd0, 16'd0, STAT_OK},
    '{8'hFF, 1'b0, 1'b0, 16'd0, 16'd0, STAT_OK},
    '{8'hFF, 1'b0, 1'b0, 16'd0, 16'd0, STAT_OK},
    '{8'hFF, 1'b0, 1'b0, 16'd0, 16'd0, STAT_OK},
    '{8'hFF, 1'b1, 1'b1, 16'd16, 16'd16, STAT_OK},
    // high profile with scaling lists, checked by the predictor
    '{8'h64, 1'b0, 1'b0, 16'd0, 16'd0, STAT_OK},
    '{8'h00, 1'b0, 1'b0, 16'd0, 16'd0, STAT_OK},
    '{8'h28, 1'b0, 1'b0, 16'd0, 16'd0, STAT_OK},
    '{8'hFF, 1'b1, 1'b0, 16'd0, 16'd0, STAT_OK}
  };

  // ---------------- sender and predictor ----------------
  always @(posedge clk) begin : sender
    sps_row_t  row;
    size_res_t res;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        row = byte_q.pop_front();
        if (size_of_byte(row.data, row.last, res)) begin
          if (row.typed) size_q.push_back('{row.width, row.height, row.status});
          else size_q.push_back(res);
        end
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the request until taken
      end else if (byte_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= byte_q[0].data;
        s_axis_tlast  <= byte_q[0].last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- receiver and checker ----------------
  always @(posedge clk) begin : receiver
    size_res_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (size_q.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("unexpected size request: %h", m_axis_tdata);
        end else begin
          want = size_q.pop_front();
          if (m_axis_tdata[15:0] !== want.width || m_axis_tdata[31:16] !== want.height ||
              m_axis_tdata[33:32] !== want.status || m_axis_tdata[39:34] !== '0) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: exp w=%0d h=%0d st=%0d got w=%0d h=%0d st=%0d pad=%h",
                       want.width, want.height, want.status, m_axis_tdata[15:0],
                       m_axis_tdata[31:16], m_axis_tdata[33:32], m_axis_tdata[39:34]);
          end
        end
      end
      if (hold_kick != hold_seen) begin
        hold_seen <= hold_kick;
        hold_left <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic drain();
    while (byte_q.size() != 0 || size_q.size() != 0 || s_axis_tvalid) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    pred_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) byte_q.push_back(dir_rows[i]);
    drain();

    snd_idle = 14;
    rcv_idle = 52;
    add_random(400);
    drain();

    snd_idle = 52;
    rcv_idle = 14;
    add_random(400);
    drain();

    // no idling, plus one long receiver stall to fill the input queue
    snd_idle = 0;
    rcv_idle = 0;
    add_random(400);
    repeat (200) @(posedge clk);
    hold_kick++;
    drain();

    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### h264_sps_size_parser.f
sv/hsps_pkg.sv
sv/hsps_fifo.sv
sv/hsps_core.sv
sv/h264_sps_size_parser.sv
verif/tb_h264_sps_size_parser.sv
